### rtl/throttle_safety_limiter_macros.svh
// Assertion macros for the throttle safety limiter checker.
// Needs a clock i_clk and an active-low reset i_rst_n in the including scope.
`ifndef THROTTLE_SAFETY_LIMITER_MACROS_SVH
`define THROTTLE_SAFETY_LIMITER_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted
`define TSL_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("tsl check failed");

// Next-cycle implication, disabled while reset is asserted
`define TSL_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("tsl check failed");

`endif

### rtl/tsl_pkg.sv
// Shared types and constants for the throttle safety limiter.
// No dependencies; used by tsl_rules, the top level and the checker.
package tsl_pkg;

    localparam int PCT_W      = 7;
    localparam int GEAR_W     = 2;
    localparam int MODE_W     = 2;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 7;

    localparam logic [PCT_W-1:0] PCT_MAX   = 7'd100;
    localparam logic [PCT_W-1:0] ECO_RESET = 7'd60;
    localparam logic [PCT_W-1:0] REV_RESET = 7'd20;

    localparam logic [GEAR_W-1:0] GEAR_PARK    = 2'd0;
    localparam logic [GEAR_W-1:0] GEAR_REVERSE = 2'd1;
    localparam logic [GEAR_W-1:0] GEAR_NEUTRAL = 2'd2;
    localparam logic [GEAR_W-1:0] GEAR_DRIVE   = 2'd3;

    localparam logic [MODE_W-1:0] MODE_EFFICIENT = 2'd0;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_BRAKE_OVERRIDE_ON = 3'd0,
        REG_ECO_CAP           = 3'd1,
        REG_REVERSE_CAP       = 3'd2,
        REG_PARK_ZERO_EN      = 3'd3,
        REG_FLOOR_PCT         = 3'd4,
        REG_CEILING_PCT       = 3'd5,
        REG_MAX_STEP_PCT      = 3'd6
    } t_cfg_idx;

    typedef struct packed {
        logic             brake_override_on;
        logic [PCT_W-1:0] eco_cap;
        logic [PCT_W-1:0] reverse_cap;
        logic             park_zero_en;
        logic [PCT_W-1:0] floor_pct;
        logic [PCT_W-1:0] ceiling_pct;
        logic [PCT_W-1:0] max_step_pct;
    } t_cfg;

    typedef struct packed {
        logic [PCT_W-1:0]  pedal_pct;
        logic              brake_pressed;
        logic [GEAR_W-1:0] gear_sel;
        logic [MODE_W-1:0] drive_mode;
    } t_item;

    typedef struct packed {
        logic brake_override;
        logic zero_park_neutral;
        logic eco_cap;
        logic reverse_cap;
        logic floor;
        logic ceiling;
    } t_flags;

    typedef struct packed {
        logic [PCT_W-1:0]  throttle_pct;
        logic [GEAR_W-1:0] gear_out;
        logic [MODE_W-1:0] mode_out;
        logic              brake_out;
        t_flags            flags;
    } t_result;

    // Write-data saturation for the percent registers
    function automatic logic [PCT_W-1:0] sat_pct(input logic [CFG_DATA_W-1:0] v);
        logic [PCT_W-1:0] r;
        r = (v > PCT_MAX) ? PCT_MAX : v[PCT_W-1:0];
        return r;
    endfunction

endpackage

### rtl/tsl_rules.sv
// Combinational rule chain and slew limiter for one item.
// Depends on tsl_pkg.
module tsl_rules (
    input  tsl_pkg::t_cfg              i_cfg,
    input  tsl_pkg::t_item             i_item,
    input  logic [tsl_pkg::PCT_W-1:0]  i_last,
    output tsl_pkg::t_result           o_result
);

    logic [tsl_pkg::PCT_W-1:0] lo;
    logic [tsl_pkg::PCT_W-1:0] thr1, thr2, thr3, thr4, thr5, thr6;
    logic [tsl_pkg::PCT_W-1:0] diff_up, diff_dn, slewed;
    logic [tsl_pkg::PCT_W:0]   up_sum;
    tsl_pkg::t_flags           flags;

    always_comb begin
        lo = (i_cfg.floor_pct > i_cfg.ceiling_pct) ? i_cfg.ceiling_pct : i_cfg.floor_pct;

        flags.brake_override = i_cfg.brake_override_on & i_item.brake_pressed;
        thr1 = flags.brake_override ? '0 : i_item.pedal_pct;

        flags.zero_park_neutral = i_cfg.park_zero_en &
                                  ((i_item.gear_sel == tsl_pkg::GEAR_PARK) ||
                                   (i_item.gear_sel == tsl_pkg::GEAR_NEUTRAL));
        thr2 = flags.zero_park_neutral ? '0 : thr1;

        flags.eco_cap = (i_item.drive_mode == tsl_pkg::MODE_EFFICIENT) &&
                        (thr2 > i_cfg.eco_cap);
        thr3 = flags.eco_cap ? i_cfg.eco_cap : thr2;

        flags.reverse_cap = (i_item.gear_sel == tsl_pkg::GEAR_REVERSE) &&
                            (thr3 > i_cfg.reverse_cap);
        thr4 = flags.reverse_cap ? i_cfg.reverse_cap : thr3;

        flags.floor = thr4 < lo;
        thr5 = flags.floor ? lo : thr4;

        flags.ceiling = thr5 > i_cfg.ceiling_pct;
        thr6 = flags.ceiling ? i_cfg.ceiling_pct : thr5;

        // slew: step of zero passes the target straight through
        diff_up = thr6 - i_last;
        diff_dn = i_last - thr6;
        up_sum  = {1'b0, i_last} + {1'b0, i_cfg.max_step_pct};
        if (i_cfg.max_step_pct == '0) begin
            slewed = thr6;
        end else if (thr6 > i_last) begin
            slewed = (diff_up > i_cfg.max_step_pct) ? up_sum[tsl_pkg::PCT_W-1:0] : thr6;
        end else begin
            slewed = (diff_dn > i_cfg.max_step_pct) ? (i_last - i_cfg.max_step_pct) : thr6;
        end

        o_result.throttle_pct = slewed;
        o_result.gear_out     = i_item.gear_sel;
        o_result.mode_out     = i_item.drive_mode;
        o_result.brake_out    = i_item.brake_pressed;
        o_result.flags        = flags;
    end

endmodule

### rtl/throttle_safety_limiter.sv
// Throttle safety limiter: takes one pedal item per clock and returns one result item per input
// transfer (input register, then the rule chain and slew limiter in one
// pass into the output register). Throughput is one item per cycle while the output side keeps
// taking results; the feedback of the last throttle through that single pass sets the figure.
// Configuration writes take effect on the next edge and should be made while the block is idle.
// Depends on tsl_pkg and tsl_rules.
module throttle_safety_limiter (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // configuration
    input  logic                                i_cfg_we,
    input  logic [tsl_pkg::CFG_IDX_W-1:0]       i_cfg_idx,
    input  logic [tsl_pkg::CFG_DATA_W-1:0]      i_cfg_data,
    // input channel
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  logic [tsl_pkg::PCT_W-1:0]           i_pedal_pct,
    input  logic                                i_brake_pressed,
    input  logic [tsl_pkg::GEAR_W-1:0]          i_gear_sel,
    input  logic [tsl_pkg::MODE_W-1:0]          i_drive_mode,
    // output channel
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic [tsl_pkg::PCT_W-1:0]           o_throttle_pct,
    output logic [tsl_pkg::GEAR_W-1:0]          o_gear_out,
    output logic [tsl_pkg::MODE_W-1:0]          o_mode_out,
    output logic                                o_brake_out,
    output logic                                o_flag_brake_override,
    output logic                                o_flag_zero_park_neutral,
    output logic                                o_flag_eco_cap,
    output logic                                o_flag_reverse_cap,
    output logic                                o_flag_floor,
    output logic                                o_flag_ceiling
);

    tsl_pkg::t_cfg             r_cfg;
    tsl_pkg::t_item            r_item;
    logic                      r_in_valid;
    tsl_pkg::t_result          r_out;
    logic                      r_out_valid;
    logic [tsl_pkg::PCT_W-1:0] r_last;

    tsl_pkg::t_result          n_out;
    logic                      out_free;
    logic                      advance;
    logic                      in_xfer;

    assign out_free   = !r_out_valid || i_out_ready;
    assign advance    = r_in_valid && out_free;
    assign o_in_ready = !r_in_valid || out_free;
    assign in_xfer    = i_in_valid && o_in_ready;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.brake_override_on <= 1'b1;
            r_cfg.eco_cap           <= tsl_pkg::ECO_RESET;
            r_cfg.reverse_cap       <= tsl_pkg::REV_RESET;
            r_cfg.park_zero_en      <= 1'b0;
            r_cfg.floor_pct         <= '0;
            r_cfg.ceiling_pct       <= tsl_pkg::PCT_MAX;
            r_cfg.max_step_pct      <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                tsl_pkg::REG_BRAKE_OVERRIDE_ON: r_cfg.brake_override_on <= i_cfg_data[0];
                tsl_pkg::REG_ECO_CAP:           r_cfg.eco_cap <= tsl_pkg::sat_pct(i_cfg_data);
                tsl_pkg::REG_REVERSE_CAP:
                    r_cfg.reverse_cap <= tsl_pkg::sat_pct(i_cfg_data);
                tsl_pkg::REG_PARK_ZERO_EN:      r_cfg.park_zero_en <= i_cfg_data[0];
                tsl_pkg::REG_FLOOR_PCT:
                    r_cfg.floor_pct <= tsl_pkg::sat_pct(i_cfg_data);
                tsl_pkg::REG_CEILING_PCT:
                    r_cfg.ceiling_pct <= tsl_pkg::sat_pct(i_cfg_data);
                tsl_pkg::REG_MAX_STEP_PCT:
                    r_cfg.max_step_pct <= tsl_pkg::sat_pct(i_cfg_data);
                default: ;
            endcase
        end
    end

    // input stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_item.pedal_pct     <= i_pedal_pct;
            r_item.brake_pressed <= i_brake_pressed;
            r_item.gear_sel      <= i_gear_sel;
            r_item.drive_mode    <= i_drive_mode;
        end
    end

    tsl_rules u_rules (
        .i_cfg    (r_cfg),
        .i_item   (r_item),
        .i_last   (r_last),
        .o_result (n_out)
    );

    // output stage and slew history
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_last      <= '0;
        end else begin
            if (out_free) begin
                r_out_valid <= r_in_valid;
            end
            if (advance) begin
                r_last <= n_out.throttle_pct;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid              = r_out_valid;
    assign o_throttle_pct           = r_out.throttle_pct;
    assign o_gear_out               = r_out.gear_out;
    assign o_mode_out               = r_out.mode_out;
    assign o_brake_out              = r_out.brake_out;
    assign o_flag_brake_override    = r_out.flags.brake_override;
    assign o_flag_zero_park_neutral = r_out.flags.zero_park_neutral;
    assign o_flag_eco_cap           = r_out.flags.eco_cap;
    assign o_flag_reverse_cap       = r_out.flags.reverse_cap;
    assign o_flag_floor             = r_out.flags.floor;
    assign o_flag_ceiling           = r_out.flags.ceiling;

endmodule

### rtl/tsl_checker.sv
// Port-level checks for the throttle safety limiter, bound to the top level.
// Depends on tsl_pkg and throttle_safety_limiter_macros.svh.
`include "throttle_safety_limiter_macros.svh"

module tsl_checker (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                o_out_valid,
    input  logic                                i_out_ready,
    input  logic [tsl_pkg::PCT_W-1:0]           o_throttle_pct,
    input  logic [tsl_pkg::GEAR_W-1:0]          o_gear_out,
    input  logic                                o_brake_out,
    input  logic                                o_flag_brake_override,
    input  logic                                o_flag_zero_park_neutral,
    input  logic                                o_flag_reverse_cap
);

    logic pn_gear;

    assign pn_gear = (o_gear_out == tsl_pkg::GEAR_PARK) || (o_gear_out == tsl_pkg::GEAR_NEUTRAL);

    // a shown result always sits within the percent range
    `TSL_ASSERT_NOW(a_thr_range, o_out_valid, o_throttle_pct <= tsl_pkg::PCT_MAX)

    // brake override only fires with the brake pressed
    `TSL_ASSERT_NOW(a_brk_flag, o_out_valid && o_flag_brake_override, o_brake_out)

    // park/neutral and reverse flags agree with the gear carried alongside
    `TSL_ASSERT_NOW(a_pn_flag, o_out_valid && o_flag_zero_park_neutral, pn_gear)
    `TSL_ASSERT_NOW(a_rev_flag, o_out_valid && o_flag_reverse_cap, o_gear_out == tsl_pkg::GEAR_REVERSE)

    // a stalled result holds until its transfer
    `TSL_ASSERT_NEXT(a_out_hold, o_out_valid && !i_out_ready, o_out_valid && $stable(o_throttle_pct))

endmodule

bind throttle_safety_limiter tsl_checker u_tsl_checker (.*);

### dv/tb_throttle_safety_limiter.sv
// Self-checking testbench for throttle_safety_limiter: random and directed pedal traffic
// with random stalls on both channels, checked against an in-bench model of the rule chain.
// Depends on tsl_pkg and the throttle_safety_limiter RTL.
`timescale 1ns / 1ps

module tb_throttle_safety_limiter;

    localparam int CYCLE_LIMIT = 400000;
    localparam int RESET_CYCLES = 10;
    // no register sits at this index; writes to it must be dropped
    localparam logic [tsl_pkg::CFG_IDX_W-1:0] REG_UNUSED = 3'd7;

    logic                           i_clk;
    logic                           i_rst_n;
    logic                           i_cfg_we;
    logic [tsl_pkg::CFG_IDX_W-1:0]  i_cfg_idx;
    logic [tsl_pkg::CFG_DATA_W-1:0] i_cfg_data;
    logic                           i_in_valid;
    logic                           o_in_ready;
    logic [tsl_pkg::PCT_W-1:0]      i_pedal_pct;
    logic                           i_brake_pressed;
    logic [tsl_pkg::GEAR_W-1:0]     i_gear_sel;
    logic [tsl_pkg::MODE_W-1:0]     i_drive_mode;
    logic                           o_out_valid;
    logic                           i_out_ready;
    logic [tsl_pkg::PCT_W-1:0]      o_throttle_pct;
    logic [tsl_pkg::GEAR_W-1:0]     o_gear_out;
    logic [tsl_pkg::MODE_W-1:0]     o_mode_out;
    logic                           o_brake_out;
    logic                           o_flag_brake_override;
    logic                           o_flag_zero_park_neutral;
    logic                           o_flag_eco_cap;
    logic                           o_flag_reverse_cap;
    logic                           o_flag_floor;
    logic                           o_flag_ceiling;

    throttle_safety_limiter i_dut (
        .i_clk                    (i_clk),
        .i_rst_n                  (i_rst_n),
        .i_cfg_we                 (i_cfg_we),
        .i_cfg_idx                (i_cfg_idx),
        .i_cfg_data               (i_cfg_data),
        .i_in_valid               (i_in_valid),
        .o_in_ready               (o_in_ready),
        .i_pedal_pct              (i_pedal_pct),
        .i_brake_pressed          (i_brake_pressed),
        .i_gear_sel               (i_gear_sel),
        .i_drive_mode             (i_drive_mode),
        .o_out_valid              (o_out_valid),
        .i_out_ready              (i_out_ready),
        .o_throttle_pct           (o_throttle_pct),
        .o_gear_out               (o_gear_out),
        .o_mode_out               (o_mode_out),
        .o_brake_out              (o_brake_out),
        .o_flag_brake_override    (o_flag_brake_override),
        .o_flag_zero_park_neutral (o_flag_zero_park_neutral),
        .o_flag_eco_cap           (o_flag_eco_cap),
        .o_flag_reverse_cap       (o_flag_reverse_cap),
        .o_flag_floor             (o_flag_floor),
        .o_flag_ceiling           (o_flag_ceiling)
    );

    tsl_pkg::t_cfg             limiter_cfg;
    logic [tsl_pkg::PCT_W-1:0] last_cmd;
    tsl_pkg::t_item            pedal_queue[$];
    tsl_pkg::t_result          due_results[$];

    int  cycle_count = 0;
    int  err_count = 0;
    int  items_sent = 0;
    int  results_checked = 0;
    int  settings_run = 0;
    int  flag_hits[6];
    int  send_gap = 0;
    int  stall_left = 0;
    bit  in_taken = 1'b0;
    bit  hold_sender = 1'b0;
    bit  idle_off = 1'b0;

    always begin
        i_clk = 1'b1;
        #1;
        i_clk = 1'b0;
        #1;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("tb_throttle_safety_limiter: done, errors");
            $finish;
        end
    end

    // Idle lengths: mostly the shortest, sometimes a middle band, now and then a long one
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 9);
        if (r < 7)
            return 1;
        else if (r < 9)
            return $urandom_range(2, 4);
        return $urandom_range(5, 24);
    endfunction

    function automatic tsl_pkg::t_result predict_throttle(input tsl_pkg::t_item it);
        tsl_pkg::t_result          res;
        logic [tsl_pkg::PCT_W-1:0] thr;
        logic [tsl_pkg::PCT_W-1:0] lo;
        res = '0;
        thr = it.pedal_pct;
        lo = (limiter_cfg.floor_pct > limiter_cfg.ceiling_pct) ?
             limiter_cfg.ceiling_pct : limiter_cfg.floor_pct;
        if (limiter_cfg.brake_override_on && it.brake_pressed) begin
            thr = '0;
            res.flags.brake_override = 1'b1;
        end
        if (limiter_cfg.park_zero_en &&
            (it.gear_sel == tsl_pkg::GEAR_PARK || it.gear_sel == tsl_pkg::GEAR_NEUTRAL)) begin
            thr = '0;
            res.flags.zero_park_neutral = 1'b1;
        end
        if (it.drive_mode == tsl_pkg::MODE_EFFICIENT && thr > limiter_cfg.eco_cap) begin
            thr = limiter_cfg.eco_cap;
            res.flags.eco_cap = 1'b1;
        end
        if (it.gear_sel == tsl_pkg::GEAR_REVERSE && thr > limiter_cfg.reverse_cap) begin
            thr = limiter_cfg.reverse_cap;
            res.flags.reverse_cap = 1'b1;
        end
        if (thr < lo) begin
            thr = lo;
            res.flags.floor = 1'b1;
        end
        if (thr > limiter_cfg.ceiling_pct) begin
            thr = limiter_cfg.ceiling_pct;
            res.flags.ceiling = 1'b1;
        end
        // slew limit against the previous command; a zero step means no limit
        if (limiter_cfg.max_step_pct != '0) begin
            if (thr > last_cmd && (thr - last_cmd) > limiter_cfg.max_step_pct)
                thr = last_cmd + limiter_cfg.max_step_pct;
            else if (last_cmd > thr && (last_cmd - thr) > limiter_cfg.max_step_pct)
                thr = last_cmd - limiter_cfg.max_step_pct;
        end
        last_cmd = thr;
        res.throttle_pct = thr;
        res.gear_out = it.gear_sel;
        res.mode_out = it.drive_mode;
        res.brake_out = it.brake_pressed;
        return res;
    endfunction

    task automatic check_field(input string name, input int want, input int got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            err_count++;
        end
    endtask

    // Input driver
    always @(negedge i_clk) begin : drive_pedal
        tsl_pkg::t_item nxt;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else if (!i_in_valid || in_taken) begin
            if (send_gap > 0) begin
                send_gap <= send_gap - 1;
                i_in_valid <= 1'b0;
            end else if (pedal_queue.size() != 0 && !hold_sender) begin
                nxt = pedal_queue.pop_front();
                i_pedal_pct <= nxt.pedal_pct;
                i_brake_pressed <= nxt.brake_pressed;
                i_gear_sel <= nxt.gear_sel;
                i_drive_mode <= nxt.drive_mode;
                i_in_valid <= 1'b1;
                send_gap <= (idle_off || $urandom_range(0, 2) != 0) ? 0 : gap_len();
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // Output back-pressure
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            i_out_ready <= 1'b0;
        end else if (!idle_off && $urandom_range(0, 3) == 0) begin
            stall_left <= gap_len() - 1;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= 1'b1;
        end
    end

    // Monitor: check results first so a spurious one is not hidden by a same-cycle transfer
    always @(posedge i_clk) begin : watch_ports
        tsl_pkg::t_item   seen;
        tsl_pkg::t_result want;
        if (!i_rst_n) begin
            in_taken <= 1'b0;
        end else begin
            if (o_out_valid && i_out_ready) begin
                if (due_results.size() == 0) begin
                    $error("result with nothing expected: throttle_pct %0d", o_throttle_pct);
                    err_count++;
                end else begin
                    want = due_results.pop_front();
                    check_field("throttle_pct", int'(want.throttle_pct), int'(o_throttle_pct));
                    check_field("gear_out", int'(want.gear_out), int'(o_gear_out));
                    check_field("mode_out", int'(want.mode_out), int'(o_mode_out));
                    check_field("brake_out", int'(want.brake_out), int'(o_brake_out));
                    check_field("flag_brake_override", int'(want.flags.brake_override),
                                int'(o_flag_brake_override));
                    check_field("flag_zero_park_neutral", int'(want.flags.zero_park_neutral),
                                int'(o_flag_zero_park_neutral));
                    check_field("flag_eco_cap", int'(want.flags.eco_cap),
                                int'(o_flag_eco_cap));
                    check_field("flag_reverse_cap", int'(want.flags.reverse_cap),
                                int'(o_flag_reverse_cap));
                    check_field("flag_floor", int'(want.flags.floor), int'(o_flag_floor));
                    check_field("flag_ceiling", int'(want.flags.ceiling),
                                int'(o_flag_ceiling));
                    flag_hits[0] += int'(want.flags.brake_override);
                    flag_hits[1] += int'(want.flags.zero_park_neutral);
                    flag_hits[2] += int'(want.flags.eco_cap);
                    flag_hits[3] += int'(want.flags.reverse_cap);
                    flag_hits[4] += int'(want.flags.floor);
                    flag_hits[5] += int'(want.flags.ceiling);
                    results_checked++;
                end
            end
            if (i_in_valid && o_in_ready) begin
                seen.pedal_pct = i_pedal_pct;
                seen.brake_pressed = i_brake_pressed;
                seen.gear_sel = i_gear_sel;
                seen.drive_mode = i_drive_mode;
                due_results.push_back(predict_throttle(seen));
                items_sent++;
            end
            in_taken <= i_in_valid && o_in_ready;
        end
    end

    task automatic write_reg(input logic [tsl_pkg::CFG_IDX_W-1:0] idx,
                             input logic [tsl_pkg::CFG_DATA_W-1:0] data);
        logic [tsl_pkg::PCT_W-1:0] pct;
        pct = (data > tsl_pkg::PCT_MAX) ? tsl_pkg::PCT_MAX : data;
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= data;
        case (idx)
            tsl_pkg::REG_BRAKE_OVERRIDE_ON: limiter_cfg.brake_override_on = data[0];
            tsl_pkg::REG_ECO_CAP:           limiter_cfg.eco_cap = pct;
            tsl_pkg::REG_REVERSE_CAP:       limiter_cfg.reverse_cap = pct;
            tsl_pkg::REG_PARK_ZERO_EN:      limiter_cfg.park_zero_en = data[0];
            tsl_pkg::REG_FLOOR_PCT:         limiter_cfg.floor_pct = pct;
            tsl_pkg::REG_CEILING_PCT:       limiter_cfg.ceiling_pct = pct;
            tsl_pkg::REG_MAX_STEP_PCT:      limiter_cfg.max_step_pct = pct;
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic push_item(input logic [tsl_pkg::PCT_W-1:0] pedal, input bit brake,
                             input logic [tsl_pkg::GEAR_W-1:0] gear,
                             input logic [tsl_pkg::MODE_W-1:0] mode);
        tsl_pkg::t_item it;
        it.pedal_pct = pedal;
        it.brake_pressed = brake;
        it.gear_sel = gear;
        it.drive_mode = mode;
        pedal_queue.push_back(it);
    endtask

    task automatic queue_random(input int n);
        int pedal;
        int gear;
        int mode;
        @(posedge i_clk);
        repeat (n) begin
            case ($urandom_range(0, 9))
                0: pedal = 0;
                1: pedal = 100;
                2: pedal = $urandom_range(101, 127);
                3: pedal = (limiter_cfg.eco_cap + $urandom_range(0, 2) - 1) & 7'h7f;
                4: pedal = (limiter_cfg.reverse_cap + $urandom_range(0, 2) - 1) & 7'h7f;
                default: pedal = $urandom_range(0, 100);
            endcase
            gear = $urandom_range(0, 3);
            mode = $urandom_range(0, 3);
            push_item(pedal[tsl_pkg::PCT_W-1:0], $urandom_range(0, 3) == 0,
                      gear[tsl_pkg::GEAR_W-1:0], mode[tsl_pkg::MODE_W-1:0]);
        end
    endtask

    // Returns at a rising edge once nothing is in flight; optionally also needs the queue empty
    task automatic settle(input bit whole);
        do
            @(posedge i_clk);
        while ((whole && pedal_queue.size() != 0) || i_in_valid || due_results.size() != 0);
    endtask

    task automatic random_settings();
        int val;
        for (int r = tsl_pkg::REG_BRAKE_OVERRIDE_ON; r <= tsl_pkg::REG_MAX_STEP_PCT; r++) begin
            val = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 127) : $urandom_range(0, 100);
            write_reg(r[tsl_pkg::CFG_IDX_W-1:0], val[tsl_pkg::CFG_DATA_W-1:0]);
        end
        settings_run++;
    endtask

    initial begin
        int mark;
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_idx = '0;
        i_cfg_data = '0;
        i_in_valid = 1'b0;
        i_pedal_pct = '0;
        i_brake_pressed = 1'b0;
        i_gear_sel = '0;
        i_drive_mode = '0;
        i_out_ready = 1'b0;
        limiter_cfg.brake_override_on = 1'b1;
        limiter_cfg.eco_cap = tsl_pkg::ECO_RESET;
        limiter_cfg.reverse_cap = tsl_pkg::REV_RESET;
        limiter_cfg.park_zero_en = 1'b0;
        limiter_cfg.floor_pct = '0;
        limiter_cfg.ceiling_pct = tsl_pkg::PCT_MAX;
        limiter_cfg.max_step_pct = '0;
        last_cmd = '0;
        repeat (RESET_CYCLES) @(negedge i_clk);
        i_rst_n = 1'b1;

        // Reset settings: bounds of the pedal, brake override, eco and reverse caps
        settings_run++;
        @(posedge i_clk);
        push_item(7'd0, 1'b0, tsl_pkg::GEAR_DRIVE, 2'd1);
        push_item(7'd100, 1'b0, tsl_pkg::GEAR_DRIVE, 2'd1);
        push_item(7'd127, 1'b0, tsl_pkg::GEAR_DRIVE, 2'd1);
        push_item(7'd101, 1'b0, tsl_pkg::GEAR_DRIVE, 2'd2);
        push_item(7'd100, 1'b1, tsl_pkg::GEAR_DRIVE, 2'd1);
        push_item(7'd61, 1'b0, tsl_pkg::GEAR_DRIVE, tsl_pkg::MODE_EFFICIENT);
        push_item(7'd60, 1'b0, tsl_pkg::GEAR_DRIVE, tsl_pkg::MODE_EFFICIENT);
        push_item(7'd21, 1'b0, tsl_pkg::GEAR_REVERSE, 2'd1);
        push_item(7'd20, 1'b0, tsl_pkg::GEAR_REVERSE, 2'd1);
        push_item(7'd127, 1'b0, tsl_pkg::GEAR_REVERSE, tsl_pkg::MODE_EFFICIENT);
        push_item(7'd50, 1'b0, tsl_pkg::GEAR_PARK, 2'd3);
        push_item(7'd50, 1'b0, tsl_pkg::GEAR_NEUTRAL, 2'd3);
        push_item(7'd127, 1'b1, tsl_pkg::GEAR_NEUTRAL, tsl_pkg::MODE_EFFICIENT);
        push_item(7'd100, 1'b0, tsl_pkg::GEAR_DRIVE, 2'd3);
        queue_random(200);
        settle(1'b1);

        // Caps wide open, brake override off, park/neutral forced to zero
        write_reg(tsl_pkg::REG_BRAKE_OVERRIDE_ON, 7'd0);
        write_reg(tsl_pkg::REG_ECO_CAP, 7'd100);
        write_reg(tsl_pkg::REG_REVERSE_CAP, 7'd100);
        write_reg(tsl_pkg::REG_PARK_ZERO_EN, 7'd1);
        write_reg(tsl_pkg::REG_FLOOR_PCT, 7'd0);
        write_reg(tsl_pkg::REG_CEILING_PCT, 7'd100);
        write_reg(tsl_pkg::REG_MAX_STEP_PCT, 7'd0);
        settings_run++;
        @(posedge i_clk);
        push_item(7'd80, 1'b0, tsl_pkg::GEAR_PARK, 2'd1);
        push_item(7'd80, 1'b0, tsl_pkg::GEAR_NEUTRAL, 2'd1);
        push_item(7'd80, 1'b1, tsl_pkg::GEAR_PARK, tsl_pkg::MODE_EFFICIENT);
        queue_random(200);
        settle(1'b1);

        // Caps at zero, a window clamp and a small slew step; back-to-back transfers
        write_reg(tsl_pkg::REG_BRAKE_OVERRIDE_ON, 7'd1);
        write_reg(tsl_pkg::REG_ECO_CAP, 7'd0);
        write_reg(tsl_pkg::REG_REVERSE_CAP, 7'd0);
        write_reg(tsl_pkg::REG_PARK_ZERO_EN, 7'd0);
        write_reg(tsl_pkg::REG_FLOOR_PCT, 7'd30);
        write_reg(tsl_pkg::REG_CEILING_PCT, 7'd70);
        write_reg(tsl_pkg::REG_MAX_STEP_PCT, 7'd5);
        settings_run++;
        idle_off = 1'b1;
        @(posedge i_clk);
        push_item(7'd100, 1'b0, tsl_pkg::GEAR_DRIVE, 2'd1);
        push_item(7'd0, 1'b0, tsl_pkg::GEAR_DRIVE, 2'd1);
        queue_random(200);
        settle(1'b1);
        idle_off = 1'b0;

        // Floor above ceiling, full-scale step, saturating writes, a write to no register
        write_reg(tsl_pkg::REG_FLOOR_PCT, 7'd80);
        write_reg(tsl_pkg::REG_CEILING_PCT, 7'd40);
        write_reg(tsl_pkg::REG_MAX_STEP_PCT, 7'd100);
        write_reg(tsl_pkg::REG_ECO_CAP, 7'd127);
        write_reg(tsl_pkg::REG_REVERSE_CAP, 7'd127);
        write_reg(REG_UNUSED, 7'd9);
        settings_run++;
        @(posedge i_clk);
        push_item(7'd0, 1'b0, tsl_pkg::GEAR_DRIVE, 2'd1);
        push_item(7'd127, 1'b0, tsl_pkg::GEAR_DRIVE, 2'd1);
        queue_random(220);
        // hold the sender mid-stream until the pipe has drained
        mark = items_sent + 100;
        do
            @(negedge i_clk);
        while (items_sent < mark);
        @(posedge i_clk);
        hold_sender = 1'b1;
        settle(1'b0);
        hold_sender = 1'b0;
        settle(1'b1);

        // Only bit 0 of the single-bit registers counts; floor 100 over ceiling 0
        write_reg(tsl_pkg::REG_BRAKE_OVERRIDE_ON, 7'd2);
        write_reg(tsl_pkg::REG_PARK_ZERO_EN, 7'd127);
        write_reg(tsl_pkg::REG_FLOOR_PCT, 7'd100);
        write_reg(tsl_pkg::REG_CEILING_PCT, 7'd0);
        write_reg(tsl_pkg::REG_MAX_STEP_PCT, 7'd1);
        write_reg(tsl_pkg::REG_ECO_CAP, 7'd55);
        write_reg(tsl_pkg::REG_REVERSE_CAP, 7'd33);
        settings_run++;
        queue_random(200);
        settle(1'b1);

        repeat (4) begin
            random_settings();
            queue_random(220);
            settle(1'b1);
        end

        repeat (6) @(posedge i_clk);
        if (due_results.size() != 0) begin
            $error("%0d expected results never arrived", due_results.size());
            err_count++;
        end
        $display("%0d pedal transfers, %0d results checked, %0d register settings",
                 items_sent, results_checked, settings_run);
        $display("rule hits: brake %0d, park/neutral %0d, eco %0d, reverse %0d,",
                 flag_hits[0], flag_hits[1], flag_hits[2], flag_hits[3]);
        $display("           floor %0d, ceiling %0d", flag_hits[4], flag_hits[5]);
        if (err_count == 0)
            $display("tb_throttle_safety_limiter: done, clean");
        else
            $display("tb_throttle_safety_limiter: done, errors");
        $finish;
    end

endmodule
